// ===== hw/rtl/rdrg_pkg.sv =====
// Package: shared constants, register map, codes and helpers of the rear risk grader.
`timescale 1ns / 1ps
`default_nettype none

package rdrg_pkg;

  localparam int unsigned COORD_BITS_DEF    = 12;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned CFG_ADDR_BITS = 5;
  localparam int unsigned CLASS_BITS    = 8;

  // register reset values
  localparam int unsigned RST_FRAME_WIDTH  = 640;
  localparam int unsigned RST_FRAME_HEIGHT = 480;
  localparam int unsigned RST_LEFT_ZONE    = 21845;
  localparam int unsigned RST_RIGHT_ZONE   = 43690;
  localparam int unsigned RST_CONF_FLOOR   = 32768;
  localparam int unsigned RST_DANGER_AREA  = 16384;
  localparam int unsigned RST_CLOSE_AREA   = 6554;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_LEFT_ZONE    = 3'd2,
    REG_RIGHT_ZONE   = 3'd3,
    REG_CONF_FLOOR   = 3'd4,
    REG_DANGER_AREA  = 3'd5,
    REG_CLOSE_AREA   = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    RISK_NORMAL    = 2'd0,
    RISK_HINT      = 2'd1,
    RISK_WARNING   = 2'd2,
    RISK_EMERGENCY = 2'd3
  } risk_e;

  typedef enum logic [1:0] {
    ZONE_LEFT   = 2'd0,
    ZONE_CENTER = 2'd1,
    ZONE_RIGHT  = 2'd2
  } zone_e;

  // detector classes that count as rear traffic
  localparam logic [CLASS_BITS-1:0] CLS_PERSON     = 8'd0;
  localparam logic [CLASS_BITS-1:0] CLS_BICYCLE    = 8'd1;
  localparam logic [CLASS_BITS-1:0] CLS_CAR        = 8'd2;
  localparam logic [CLASS_BITS-1:0] CLS_MOTORCYCLE = 8'd3;
  localparam logic [CLASS_BITS-1:0] CLS_BUS        = 8'd5;
  localparam logic [CLASS_BITS-1:0] CLS_TRUCK      = 8'd7;

  // control word of a qualified item between the two stages
  typedef struct packed {
    logic  counts;
    logic  size_ok;
    logic  last;
    zone_e zone;
  } item_ctl_t;

  function automatic logic class_counts(logic [CLASS_BITS-1:0] cls);
    logic hit;
    case (cls) inside
      CLS_PERSON, CLS_BICYCLE, CLS_CAR, CLS_MOTORCYCLE, CLS_BUS, CLS_TRUCK: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rdrg_if.sv =====
// Interfaces: detection input stream and grade result stream.
`timescale 1ns / 1ps
`default_nettype none

interface rdrg_det_if #(
  parameter int unsigned COORD_BITS    = rdrg_pkg::COORD_BITS_DEF,
  parameter int unsigned FRACTION_BITS = rdrg_pkg::FRACTION_BITS_DEF
);
  import rdrg_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     is_detection;
  logic [CLASS_BITS-1:0]    class_index;
  logic [FRACTION_BITS-1:0] confidence_level;
  logic [COORD_BITS-1:0]    box_left;
  logic [COORD_BITS-1:0]    box_top;
  logic [COORD_BITS-1:0]    box_right;
  logic [COORD_BITS-1:0]    box_bottom;
  logic                     last_in_frame;

  modport source (
    output valid, is_detection, class_index, confidence_level,
           box_left, box_top, box_right, box_bottom, last_in_frame,
    input  ready
  );
  modport sink (
    input  valid, is_detection, class_index, confidence_level,
           box_left, box_top, box_right, box_bottom, last_in_frame,
    output ready
  );
endinterface

interface rdrg_res_if;
  logic valid;
  logic ready;
  logic left_occupied;
  logic center_occupied;
  logic right_occupied;
  logic [1:0] risk_level;

  modport source (
    output valid, left_occupied, center_occupied, right_occupied, risk_level,
    input  ready
  );
  modport sink (
    input  valid, left_occupied, center_occupied, right_occupied, risk_level,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/rear_detection_risk_grader.sv =====
// Top level: rear detection risk grader with APB-style register port.
`timescale 1ns / 1ps
`default_nettype none

// Takes one detection beat per cycle while det_i.ready is high and returns one
// result beat on each beat marked last_in_frame. A beat passes an input
// register, a filter/zone/area stage and an accumulate/grade stage; the
// output register decouples a stalled sink, which holds back only a
// last_in_frame beat while a result waits. The clock period is set by the
// 12x16 zone multiply in the first stage and the 16x24 threshold multiply in
// the second.
// The frame area used for grading is registered from the size registers and
// is updated in the cycle after a register write.
module rear_detection_risk_grader #(
  parameter int unsigned COORD_BITS    = rdrg_pkg::COORD_BITS_DEF,
  parameter int unsigned FRACTION_BITS = rdrg_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  rdrg_det_if.sink                                det_i,
  rdrg_res_if.source                              res_o,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [rdrg_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [rdrg_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic      [rdrg_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                                    pready
);
  import rdrg_pkg::*;

  logic [COORD_BITS-1:0]    frame_width, frame_height;
  logic [FRACTION_BITS-1:0] left_zone, right_zone, conf_floor;
  logic [FRACTION_BITS-1:0] danger_area, close_area;
  logic [2*COORD_BITS-1:0]  frame_area;

  logic                     item_valid, item_take;
  item_ctl_t                item_ctl;
  logic [2*COORD_BITS-1:0]  item_area;

  rdrg_cfg_regs #(
    .COORD_BITS    (COORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .frame_width_o  (frame_width),
    .frame_height_o (frame_height),
    .left_zone_o    (left_zone),
    .right_zone_o   (right_zone),
    .conf_floor_o   (conf_floor),
    .danger_area_o  (danger_area),
    .close_area_o   (close_area),
    .frame_area_o   (frame_area)
  );

  rdrg_qualify #(
    .COORD_BITS    (COORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_qualify (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .det_i          (det_i),
    .frame_width_i  (frame_width),
    .frame_height_i (frame_height),
    .left_zone_i    (left_zone),
    .right_zone_i   (right_zone),
    .conf_floor_i   (conf_floor),
    .item_valid_o   (item_valid),
    .item_ctl_o     (item_ctl),
    .item_area_o    (item_area),
    .item_take_i    (item_take)
  );

  rdrg_grade #(
    .COORD_BITS    (COORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_grade (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_ctl_i    (item_ctl),
    .item_area_i   (item_area),
    .item_take_o   (item_take),
    .danger_area_i (danger_area),
    .close_area_i  (close_area),
    .frame_area_i  (frame_area),
    .res_o         (res_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/rdrg_cfg_regs.sv =====
// Configuration registers behind the APB-style port, plus the registered frame area.
`timescale 1ns / 1ps
`default_nettype none

module rdrg_cfg_regs #(
  parameter int unsigned COORD_BITS    = rdrg_pkg::COORD_BITS_DEF,
  parameter int unsigned FRACTION_BITS = rdrg_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [rdrg_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [rdrg_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic      [rdrg_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                                    pready,
  output logic      [COORD_BITS-1:0]              frame_width_o,
  output logic      [COORD_BITS-1:0]              frame_height_o,
  output logic      [FRACTION_BITS-1:0]           left_zone_o,
  output logic      [FRACTION_BITS-1:0]           right_zone_o,
  output logic      [FRACTION_BITS-1:0]           conf_floor_o,
  output logic      [FRACTION_BITS-1:0]           danger_area_o,
  output logic      [FRACTION_BITS-1:0]           close_area_o,
  output logic      [2*COORD_BITS-1:0]            frame_area_o
);
  import rdrg_pkg::*;

  logic [COORD_BITS-1:0]    frame_width_q, frame_height_q;
  logic [FRACTION_BITS-1:0] left_zone_q, right_zone_q, conf_floor_q;
  logic [FRACTION_BITS-1:0] danger_area_q, close_area_q;
  logic [2*COORD_BITS-1:0]  frame_area_q, frame_area_d;
  logic                     wr_en;
  reg_idx_e                 idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[CFG_ADDR_BITS-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= COORD_BITS'(RST_FRAME_WIDTH);
      frame_height_q <= COORD_BITS'(RST_FRAME_HEIGHT);
      left_zone_q    <= FRACTION_BITS'(RST_LEFT_ZONE);
      right_zone_q   <= FRACTION_BITS'(RST_RIGHT_ZONE);
      conf_floor_q   <= FRACTION_BITS'(RST_CONF_FLOOR);
      danger_area_q  <= FRACTION_BITS'(RST_DANGER_AREA);
      close_area_q   <= FRACTION_BITS'(RST_CLOSE_AREA);
    end else if (wr_en) begin
      unique case (idx)
        REG_FRAME_WIDTH:  frame_width_q  <= pwdata[COORD_BITS-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= pwdata[COORD_BITS-1:0];
        REG_LEFT_ZONE:    left_zone_q    <= pwdata[FRACTION_BITS-1:0];
        REG_RIGHT_ZONE:   right_zone_q   <= pwdata[FRACTION_BITS-1:0];
        REG_CONF_FLOOR:   conf_floor_q   <= pwdata[FRACTION_BITS-1:0];
        REG_DANGER_AREA:  danger_area_q  <= pwdata[FRACTION_BITS-1:0];
        REG_CLOSE_AREA:   close_area_q   <= pwdata[FRACTION_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FRAME_WIDTH:  prdata = CFG_DATA_BITS'(frame_width_q);
      REG_FRAME_HEIGHT: prdata = CFG_DATA_BITS'(frame_height_q);
      REG_LEFT_ZONE:    prdata = CFG_DATA_BITS'(left_zone_q);
      REG_RIGHT_ZONE:   prdata = CFG_DATA_BITS'(right_zone_q);
      REG_CONF_FLOOR:   prdata = CFG_DATA_BITS'(conf_floor_q);
      REG_DANGER_AREA:  prdata = CFG_DATA_BITS'(danger_area_q);
      REG_CLOSE_AREA:   prdata = CFG_DATA_BITS'(close_area_q);
      default:          prdata = '0;
    endcase
  end

  // area product is only needed by the second stage, so it can be registered
  assign frame_area_d = (2*COORD_BITS)'(frame_width_q) * (2*COORD_BITS)'(frame_height_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_area_q <= (2*COORD_BITS)'(RST_FRAME_WIDTH * RST_FRAME_HEIGHT);
    end else begin
      frame_area_q <= frame_area_d;
    end
  end

  assign frame_width_o  = frame_width_q;
  assign frame_height_o = frame_height_q;
  assign left_zone_o    = left_zone_q;
  assign right_zone_o   = right_zone_q;
  assign conf_floor_o   = conf_floor_q;
  assign danger_area_o  = danger_area_q;
  assign close_area_o   = close_area_q;
  assign frame_area_o   = frame_area_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rdrg_qualify.sv =====
// First stage: input register, class/confidence filter, zone pick and box area.
`timescale 1ns / 1ps
`default_nettype none

module rdrg_qualify #(
  parameter int unsigned COORD_BITS    = rdrg_pkg::COORD_BITS_DEF,
  parameter int unsigned FRACTION_BITS = rdrg_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  rdrg_det_if.sink                       det_i,
  input  wire logic [COORD_BITS-1:0]     frame_width_i,
  input  wire logic [COORD_BITS-1:0]     frame_height_i,
  input  wire logic [FRACTION_BITS-1:0]  left_zone_i,
  input  wire logic [FRACTION_BITS-1:0]  right_zone_i,
  input  wire logic [FRACTION_BITS-1:0]  conf_floor_i,
  output logic                           item_valid_o,
  output rdrg_pkg::item_ctl_t            item_ctl_o,
  output logic      [2*COORD_BITS-1:0]   item_area_o,
  input  wire logic                      item_take_i
);
  import rdrg_pkg::*;

  localparam int unsigned PROD_BITS = COORD_BITS + FRACTION_BITS;
  localparam int unsigned CX_BITS   = PROD_BITS + 1;

  // input register
  logic                     v1_q;
  logic                     is_det_q, last_q;
  logic [CLASS_BITS-1:0]    cls_q;
  logic [FRACTION_BITS-1:0] conf_q;
  logic [COORD_BITS-1:0]    bl_q, bt_q, br_q, bb_q;

  // stage register toward the grader
  logic                     v2_q;
  item_ctl_t                ctl_q, ctl_d;
  logic [2*COORD_BITS-1:0]  area_q, area_d;

  logic                     en1, en2;
  logic                     size_ok;
  logic [COORD_BITS:0]      sum_x;
  logic [PROD_BITS-1:0]     lprod, rprod;
  logic [CX_BITS-1:0]       cx2, lb2, rb2;
  logic [COORD_BITS-1:0]    dx, dy;

  assign en2         = !v2_q || item_take_i;
  assign en1         = !v1_q || en2;
  assign det_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en1) begin
      v1_q <= det_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && det_i.valid) begin
      is_det_q <= det_i.is_detection;
      cls_q    <= det_i.class_index;
      conf_q   <= det_i.confidence_level;
      bl_q     <= det_i.box_left;
      bt_q     <= det_i.box_top;
      br_q     <= det_i.box_right;
      bb_q     <= det_i.box_bottom;
      last_q   <= det_i.last_in_frame;
    end
  end

  // center compare is done at twice the scale so the halving stays exact
  assign size_ok = (frame_width_i != '0) && (frame_height_i != '0);
  assign sum_x   = {1'b0, bl_q} + {1'b0, br_q};
  assign cx2     = {sum_x, {FRACTION_BITS{1'b0}}};
  assign lprod   = PROD_BITS'(frame_width_i) * PROD_BITS'(left_zone_i);
  assign rprod   = PROD_BITS'(frame_width_i) * PROD_BITS'(right_zone_i);
  assign lb2     = {lprod, 1'b0};
  assign rb2     = {rprod, 1'b0};

  // inverted boxes collapse to zero span
  assign dx     = (br_q >= bl_q) ? (br_q - bl_q) : '0;
  assign dy     = (bb_q >= bt_q) ? (bb_q - bt_q) : '0;
  assign area_d = (2*COORD_BITS)'(dx) * (2*COORD_BITS)'(dy);

  always_comb begin
    ctl_d.counts  = is_det_q && size_ok && class_counts(cls_q) && (conf_q >= conf_floor_i);
    ctl_d.size_ok = size_ok;
    ctl_d.last    = last_q;
    if (cx2 < lb2) begin
      ctl_d.zone = ZONE_LEFT;
    end else if (cx2 > rb2) begin
      ctl_d.zone = ZONE_RIGHT;
    end else begin
      ctl_d.zone = ZONE_CENTER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      ctl_q  <= ctl_d;
      area_q <= area_d;
    end
  end

  assign item_valid_o = v2_q;
  assign item_ctl_o   = ctl_q;
  assign item_area_o  = area_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rdrg_grade.sv =====
// Second stage: area grading, per-frame accumulation and the result register.
`timescale 1ns / 1ps
`default_nettype none

module rdrg_grade #(
  parameter int unsigned COORD_BITS    = rdrg_pkg::COORD_BITS_DEF,
  parameter int unsigned FRACTION_BITS = rdrg_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      item_valid_i,
  input  wire rdrg_pkg::item_ctl_t       item_ctl_i,
  input  wire logic [2*COORD_BITS-1:0]   item_area_i,
  output logic                           item_take_o,
  input  wire logic [FRACTION_BITS-1:0]  danger_area_i,
  input  wire logic [FRACTION_BITS-1:0]  close_area_i,
  input  wire logic [2*COORD_BITS-1:0]   frame_area_i,
  rdrg_res_if.source                     res_o
);
  import rdrg_pkg::*;

  localparam int unsigned THR_BITS = 2*COORD_BITS + FRACTION_BITS;

  logic                left_q, center_q, right_q;
  logic                left_d, center_d, right_d;
  risk_e               worst_q, worst_d, risk;
  logic                fire;

  logic                out_v_q;
  logic                out_left_q, out_center_q, out_right_q;
  risk_e               out_risk_q;

  logic [THR_BITS-1:0] thr_danger, thr_close, scaled;

  // non-last beats never need the result register
  assign item_take_o = !item_ctl_i.last || !out_v_q || res_o.ready;
  assign fire        = item_valid_i && item_take_o;

  assign thr_danger = THR_BITS'(danger_area_i) * THR_BITS'(frame_area_i);
  assign thr_close  = THR_BITS'(close_area_i) * THR_BITS'(frame_area_i);
  assign scaled     = {item_area_i, {FRACTION_BITS{1'b0}}};

  always_comb begin
    if (scaled >= thr_danger) begin
      risk = RISK_EMERGENCY;
    end else if (scaled >= thr_close) begin
      risk = RISK_WARNING;
    end else if ({scaled, 1'b0} >= {1'b0, thr_close}) begin
      risk = RISK_HINT;
    end else begin
      risk = RISK_NORMAL;
    end
  end

  always_comb begin
    left_d   = left_q;
    center_d = center_q;
    right_d  = right_q;
    worst_d  = worst_q;
    if (item_ctl_i.counts) begin
      case (item_ctl_i.zone)
        ZONE_LEFT:  left_d   = 1'b1;
        ZONE_RIGHT: right_d  = 1'b1;
        default:    center_d = 1'b1;
      endcase
      if (risk > worst_q) begin
        worst_d = risk;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= 1'b0;
      center_q <= 1'b0;
      right_q  <= 1'b0;
      worst_q  <= RISK_NORMAL;
    end else if (fire) begin
      if (item_ctl_i.last) begin
        left_q   <= 1'b0;
        center_q <= 1'b0;
        right_q  <= 1'b0;
        worst_q  <= RISK_NORMAL;
      end else begin
        left_q   <= left_d;
        center_q <= center_d;
        right_q  <= right_d;
        worst_q  <= worst_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (fire && item_ctl_i.last) begin
      out_v_q <= 1'b1;
    end else if (res_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  // zero frame size blanks the whole result
  always_ff @(posedge clk_i) begin
    if (fire && item_ctl_i.last) begin
      out_left_q   <= item_ctl_i.size_ok && left_d;
      out_center_q <= item_ctl_i.size_ok && center_d;
      out_right_q  <= item_ctl_i.size_ok && right_d;
      out_risk_q   <= item_ctl_i.size_ok ? worst_d : RISK_NORMAL;
    end
  end

  assign res_o.valid           = out_v_q;
  assign res_o.left_occupied   = out_left_q;
  assign res_o.center_occupied = out_center_q;
  assign res_o.right_occupied  = out_right_q;
  assign res_o.risk_level      = out_risk_q;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for the rear detection risk grader: detection stream, grade checks, register sweeps.
`timescale 1ns / 1ps

module tb_top;
  import rdrg_pkg::*;

  localparam int COORD_W        = COORD_BITS_DEF;
  localparam int FRAC_W         = FRACTION_BITS_DEF;
  localparam int COORD_MAX      = (1 << COORD_W) - 1;
  localparam int FRAC_MAX       = (1 << FRAC_W) - 1;
  localparam int LIMIT_CYCLES   = 200000;
  localparam int RANDOM_PHASES  = 8;
  localparam int BEATS_PER_PASS = 88;
  localparam int SETTLE_CYCLES  = 6;

  // index past the register map; writes there must be dropped
  localparam logic [2:0] REG_SPARE = 3'd7;

  // classes outside the rear traffic set
  localparam logic [CLASS_BITS-1:0] CLS_AIRPLANE = 8'd4;
  localparam logic [CLASS_BITS-1:0] CLS_TRAIN    = 8'd6;
  localparam logic [CLASS_BITS-1:0] CLS_BOAT     = 8'd8;
  localparam logic [CLASS_BITS-1:0] CLS_TOP      = 8'd255;

  localparam logic [CLASS_BITS-1:0] REAR_CLASSES [6] = '{
    CLS_PERSON, CLS_BICYCLE, CLS_CAR, CLS_MOTORCYCLE, CLS_BUS, CLS_TRUCK
  };

  typedef logic [COORD_W-1:0]    coord_t;
  typedef logic [FRAC_W-1:0]     frac_t;
  typedef logic [CLASS_BITS-1:0] cls_t;

  typedef struct packed {
    logic   is_det;
    cls_t   cls;
    frac_t  conf;
    coord_t bl;
    coord_t bt;
    coord_t br;
    coord_t bb;
    logic   last;
  } det_beat_t;

  typedef struct packed {
    logic  left;
    logic  center;
    logic  right;
    risk_e risk;
  } grade_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  rdrg_det_if det_if ();
  rdrg_res_if res_if ();

  rear_detection_risk_grader i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .det_i   (det_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // register shadow and per-frame accumulation
  coord_t cfg_width;
  coord_t cfg_height;
  frac_t  cfg_left_frac;
  frac_t  cfg_right_frac;
  frac_t  cfg_floor;
  frac_t  cfg_danger;
  frac_t  cfg_close;

  logic  seen_left;
  logic  seen_center;
  logic  seen_right;
  risk_e worst_grade;

  det_beat_t beats_due[$];
  grade_t    grades_due[$];
  det_beat_t beat_on_bus;

  int beats_queued   = 0;
  int beats_taken    = 0;
  int grades_checked = 0;
  int reg_writes     = 0;
  int mismatches     = 0;
  int idle_pct       = 0;
  int src_gap        = 0;
  int snk_gap        = 0;
  int cycle_count    = 0;

  // Accumulate one accepted beat; on last_in_frame queue the frame grade.
  function automatic void grade_beat(det_beat_t b);
    logic [63:0] w64, h64, cx2, lb2, rb2, dw, dh, area, farea, scaled;
    logic        size_ok;
    logic        counted;
    risk_e       r;
    grade_t      g;
    w64     = 64'(cfg_width);
    h64     = 64'(cfg_height);
    size_ok = (cfg_width != 0) && (cfg_height != 0);
    case (b.cls)
      CLS_PERSON, CLS_BICYCLE, CLS_CAR, CLS_MOTORCYCLE, CLS_BUS, CLS_TRUCK: counted = 1'b1;
      default: counted = 1'b0;
    endcase
    if (b.is_det && size_ok && counted && b.conf >= cfg_floor) begin
      cx2 = (64'(b.bl) + 64'(b.br)) << FRAC_W;
      lb2 = 64'd2 * w64 * 64'(cfg_left_frac);
      rb2 = 64'd2 * w64 * 64'(cfg_right_frac);
      dw  = (b.br >= b.bl) ? 64'(b.br - b.bl) : 64'd0;
      dh  = (b.bb >= b.bt) ? 64'(b.bb - b.bt) : 64'd0;
      area   = dw * dh;
      farea  = w64 * h64;
      scaled = area << FRAC_W;
      if (cx2 < lb2) begin
        seen_left = 1'b1;
      end else if (cx2 > rb2) begin
        seen_right = 1'b1;
      end else begin
        seen_center = 1'b1;
      end
      if (scaled >= 64'(cfg_danger) * farea) begin
        r = RISK_EMERGENCY;
      end else if (scaled >= 64'(cfg_close) * farea) begin
        r = RISK_WARNING;
      end else if ((scaled << 1) >= 64'(cfg_close) * farea) begin
        r = RISK_HINT;
      end else begin
        r = RISK_NORMAL;
      end
      if (r > worst_grade) begin
        worst_grade = r;
      end
    end
    if (b.last) begin
      if (size_ok) begin
        g = '{seen_left, seen_center, seen_right, worst_grade};
      end else begin
        g = '{1'b0, 1'b0, 1'b0, RISK_NORMAL};
      end
      grades_due.push_back(g);
      seen_left   = 1'b0;
      seen_center = 1'b0;
      seen_right  = 1'b0;
      worst_grade = RISK_NORMAL;
    end
  endfunction

  function automatic det_beat_t mk_beat(logic is_det, cls_t cls, int conf,
                                        int l, int t, int r, int b, logic last);
    det_beat_t d;
    d = '{is_det, cls, frac_t'(conf), coord_t'(l), coord_t'(t), coord_t'(r),
          coord_t'(b), last};
    return d;
  endfunction

  function automatic det_beat_t rand_beat();
    det_beat_t d;
    int        lim_w, lim_h, span_w, span_h, edge_r, edge_b;
    d.is_det = ($urandom_range(0, 99) >= 8);
    if ($urandom_range(0, 3) != 0) begin
      d.cls = REAR_CLASSES[$urandom_range(0, 5)];
    end else begin
      d.cls = cls_t'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 9) < 7) begin
      d.conf = frac_t'($urandom_range(int'(cfg_floor), FRAC_MAX));
    end else begin
      d.conf = frac_t'($urandom_range(0, FRAC_MAX));
    end
    if ($urandom_range(0, 99) < 85) begin
      // well-formed box starting inside the frame, size spread over many scales
      lim_w  = (cfg_width == 0) ? COORD_MAX : int'(cfg_width);
      lim_h  = (cfg_height == 0) ? COORD_MAX : int'(cfg_height);
      span_w = $urandom_range(0, (1 << $urandom_range(1, COORD_W)) - 1);
      span_h = $urandom_range(0, (1 << $urandom_range(1, COORD_W)) - 1);
      d.bl   = coord_t'($urandom_range(0, lim_w));
      d.bt   = coord_t'($urandom_range(0, lim_h));
      edge_r = int'(d.bl) + span_w;
      edge_b = int'(d.bt) + span_h;
      d.br   = coord_t'((edge_r > COORD_MAX) ? COORD_MAX : edge_r);
      d.bb   = coord_t'((edge_b > COORD_MAX) ? COORD_MAX : edge_b);
    end else begin
      d.bl = coord_t'($urandom_range(0, COORD_MAX));
      d.bt = coord_t'($urandom_range(0, COORD_MAX));
      d.br = coord_t'($urandom_range(0, COORD_MAX));
      d.bb = coord_t'($urandom_range(0, COORD_MAX));
    end
    d.last = ($urandom_range(0, 3) == 0);
    return d;
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(0, 5))
      0: return COORD_MAX;
      1: return $urandom_range(1, 64);
      default: return $urandom_range(16, COORD_MAX);
    endcase
  endfunction

  function automatic int pick_frac();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return FRAC_MAX;
      default: return $urandom_range(0, FRAC_MAX);
    endcase
  endfunction

  task automatic send(det_beat_t d);
    beats_due.push_back(d);
    beats_queued++;
  endtask

  // APB write: setup, then access; shadow is updated once the access completes
  task automatic cfg_write(logic [2:0] idx, int unsigned value);
    logic [CFG_DATA_BITS-1:0] data;
    logic [CFG_DATA_BITS-1:0] junk;
    data = CFG_DATA_BITS'(value);
    junk = CFG_DATA_BITS'($urandom());
    if ($urandom_range(0, 1) == 1) begin
      if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) begin
        data = data | (junk & ~CFG_DATA_BITS'(COORD_MAX));
      end else begin
        data = data | (junk & ~CFG_DATA_BITS'(FRAC_MAX));
      end
    end
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  cfg_width      = data[COORD_W-1:0];
      REG_FRAME_HEIGHT: cfg_height     = data[COORD_W-1:0];
      REG_LEFT_ZONE:    cfg_left_frac  = data[FRAC_W-1:0];
      REG_RIGHT_ZONE:   cfg_right_frac = data[FRAC_W-1:0];
      REG_CONF_FLOOR:   cfg_floor      = data[FRAC_W-1:0];
      REG_DANGER_AREA:  cfg_danger     = data[FRAC_W-1:0];
      REG_CLOSE_AREA:   cfg_close      = data[FRAC_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // wait for every queued beat and grade, then let the pipeline empty out
  task automatic drain();
    while (beats_taken != beats_queued || grades_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // detection source
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      det_if.valid <= 1'b0;
    end else begin
      if (det_if.valid && det_if.ready) begin
        grade_beat(beat_on_bus);
        beats_taken++;
      end
      if (!det_if.valid || det_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          det_if.valid <= 1'b0;
        end else if ($urandom_range(0, 99) < idle_pct) begin
          src_gap = $urandom_range(0, 12);
          det_if.valid <= 1'b0;
        end else if (beats_due.size() > 0) begin
          beat_on_bus = beats_due.pop_front();
          det_if.is_detection     <= beat_on_bus.is_det;
          det_if.class_index      <= beat_on_bus.cls;
          det_if.confidence_level <= beat_on_bus.conf;
          det_if.box_left         <= beat_on_bus.bl;
          det_if.box_top          <= beat_on_bus.bt;
          det_if.box_right        <= beat_on_bus.br;
          det_if.box_bottom       <= beat_on_bus.bb;
          det_if.last_in_frame    <= beat_on_bus.last;
          det_if.valid            <= 1'b1;
        end else begin
          det_if.valid <= 1'b0;
        end
      end
    end
  end

  // grade sink and checker
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (grades_due.size() == 0) begin
          $display("%0t: grade beat with none expected, got L%0b C%0b R%0b risk %0d",
                   $time, res_if.left_occupied, res_if.center_occupied,
                   res_if.right_occupied, res_if.risk_level);
          mismatches++;
        end else begin
          grade_t want;
          want = grades_due.pop_front();
          check_field("left_occupied", want.left, res_if.left_occupied);
          check_field("center_occupied", want.center, res_if.center_occupied);
          check_field("right_occupied", want.right, res_if.right_occupied);
          check_field("risk_level", want.risk, res_if.risk_level);
          grades_checked++;
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        res_if.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        snk_gap = $urandom_range(0, 12);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: timeout, %0d beats accepted, %0d grades outstanding",
             $time, beats_taken, grades_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_ni                  = 1'b0;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    det_if.valid            = 1'b0;
    det_if.is_detection     = 1'b0;
    det_if.class_index      = '0;
    det_if.confidence_level = '0;
    det_if.box_left         = '0;
    det_if.box_top          = '0;
    det_if.box_right        = '0;
    det_if.box_bottom       = '0;
    det_if.last_in_frame    = 1'b0;
    res_if.ready            = 1'b0;
    cfg_width      = coord_t'(RST_FRAME_WIDTH);
    cfg_height     = coord_t'(RST_FRAME_HEIGHT);
    cfg_left_frac  = frac_t'(RST_LEFT_ZONE);
    cfg_right_frac = frac_t'(RST_RIGHT_ZONE);
    cfg_floor      = frac_t'(RST_CONF_FLOOR);
    cfg_danger     = frac_t'(RST_DANGER_AREA);
    cfg_close      = frac_t'(RST_CLOSE_AREA);
    seen_left      = 1'b0;
    seen_center    = 1'b0;
    seen_right     = 1'b0;
    worst_grade    = RISK_NORMAL;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset register values
    idle_pct = 15;
    send(mk_beat(1'b1, CLS_CAR, FRAC_MAX, 0, 0, 639, 479, 1'b1));
    send(mk_beat(1'b0, CLS_CAR, FRAC_MAX, 0, 0, 639, 479, 1'b1));
    drain();

    // 512x256 frame: zone edges at center sums 256 and 768, hint/warn/emerg
    // at areas 8192, 16384 and 32768
    cfg_write(REG_FRAME_WIDTH, 512);
    cfg_write(REG_FRAME_HEIGHT, 256);
    cfg_write(REG_LEFT_ZONE, 16384);
    cfg_write(REG_RIGHT_ZONE, 49152);
    cfg_write(REG_CONF_FLOOR, 32768);
    cfg_write(REG_DANGER_AREA, 16384);
    cfg_write(REG_CLOSE_AREA, 8192);
    cfg_write(REG_SPARE, 0);
    send(mk_beat(1'b1, CLS_PERSON, FRAC_MAX, 0, 0, 100, 100, 1'b0));
    send(mk_beat(1'b1, CLS_BICYCLE, 32768, 100, 0, 156, 128, 1'b1));
    send(mk_beat(1'b1, CLS_CAR, 32767, 0, 0, COORD_MAX, COORD_MAX, 1'b1));
    // inverted box past the right edge, then a flat box on it
    send(mk_beat(1'b1, CLS_MOTORCYCLE, 40000, 400, 0, 369, 50, 1'b0));
    send(mk_beat(1'b1, CLS_BUS, 50000, 384, 10, 384, 300, 1'b0));
    send(mk_beat(1'b1, CLS_CAR, 50000, 0, 0, 128, 128, 1'b1));
    send(mk_beat(1'b1, CLS_CAR, 50000, 0, 0, 127, 129, 1'b1));
    send(mk_beat(1'b1, CLS_TRUCK, FRAC_MAX, 200, 0, 328, 256, 1'b1));
    send(mk_beat(1'b1, CLS_TRUCK, FRAC_MAX, 0, 0, 2, COORD_MAX, 1'b0));
    send(mk_beat(1'b0, CLS_CAR, FRAC_MAX, 0, 0, COORD_MAX, COORD_MAX, 1'b1));
    send(mk_beat(1'b1, CLS_AIRPLANE, FRAC_MAX, 0, 0, COORD_MAX, COORD_MAX, 1'b0));
    send(mk_beat(1'b1, CLS_TRAIN, FRAC_MAX, 0, 0, COORD_MAX, COORD_MAX, 1'b0));
    send(mk_beat(1'b1, CLS_BOAT, FRAC_MAX, 0, 0, COORD_MAX, COORD_MAX, 1'b0));
    send(mk_beat(1'b1, CLS_TOP, FRAC_MAX, 0, 0, COORD_MAX, COORD_MAX, 1'b1));
    send(mk_beat(1'b0, CLS_TOP, FRAC_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
    send(mk_beat(1'b1, CLS_PERSON, FRAC_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                 1'b1));
    send(mk_beat(1'b1, CLS_CAR, FRAC_MAX, 0, 0, 300, 200, 1'b0));
    drain();

    // zero frame size with a frame open, then a size change mid-frame
    cfg_write(REG_FRAME_WIDTH, 0);
    send(mk_beat(1'b1, CLS_CAR, FRAC_MAX, 0, 0, 100, 100, 1'b1));
    drain();
    cfg_write(REG_FRAME_WIDTH, 512);
    cfg_write(REG_FRAME_HEIGHT, 0);
    send(mk_beat(1'b1, CLS_CAR, FRAC_MAX, 0, 0, 500, 250, 1'b0));
    drain();
    cfg_write(REG_FRAME_HEIGHT, 256);
    send(mk_beat(1'b1, CLS_BUS, FRAC_MAX, 250, 0, 260, 10, 1'b1));
    drain();

    for (int k = 0; k < RANDOM_PHASES; k++) begin
      case (k)
        0: begin
          cfg_write(REG_FRAME_WIDTH, COORD_MAX);
          cfg_write(REG_FRAME_HEIGHT, COORD_MAX);
          cfg_write(REG_LEFT_ZONE, 0);
          cfg_write(REG_RIGHT_ZONE, 0);
          cfg_write(REG_CONF_FLOOR, 0);
          cfg_write(REG_DANGER_AREA, 0);
          cfg_write(REG_CLOSE_AREA, 0);
        end
        1: begin
          cfg_write(REG_FRAME_WIDTH, 1);
          cfg_write(REG_FRAME_HEIGHT, 1);
          cfg_write(REG_LEFT_ZONE, FRAC_MAX);
          cfg_write(REG_RIGHT_ZONE, FRAC_MAX);
          cfg_write(REG_CONF_FLOOR, FRAC_MAX);
          cfg_write(REG_DANGER_AREA, FRAC_MAX);
          cfg_write(REG_CLOSE_AREA, FRAC_MAX);
        end
        default: begin
          cfg_write(REG_FRAME_WIDTH, pick_dim());
          cfg_write(REG_FRAME_HEIGHT, pick_dim());
          cfg_write(REG_LEFT_ZONE, pick_frac());
          cfg_write(REG_RIGHT_ZONE, pick_frac());
          cfg_write(REG_CONF_FLOOR, pick_frac());
          cfg_write(REG_DANGER_AREA, pick_frac());
          cfg_write(REG_CLOSE_AREA, pick_frac());
        end
      endcase
      // one stretch without gaps mid-run, and none at the tail
      idle_pct = (k == 3 || k == RANDOM_PHASES - 1) ? 0 : $urandom_range(5, 35);
      for (int n = 0; n < BEATS_PER_PASS; n++) begin
        send(rand_beat());
      end
      drain();
    end

    $display("Ran %0d detection beats across %0d register writes (zero size, extremes, random).",
             beats_taken, reg_writes);
    $display("Compared %0d frame grades, %0d mismatches.", grades_checked, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
